### sv/bfp_pkg.sv
package bfp_pkg;

    // Request codes carried in s_tuser
    localparam logic [2:0] REQ_ADD      = 3'd0;
    localparam logic [2:0] REQ_REMOVE   = 3'd1;
    localparam logic [2:0] REQ_TEST     = 3'd2;
    localparam logic [2:0] REQ_SET_BIT  = 3'd3;
    localparam logic [2:0] REQ_TEST_BIT = 3'd4;
    localparam logic [2:0] REQ_MERGE    = 3'd5;
    localparam logic [2:0] REQ_READ     = 3'd6;

    // Field widths
    localparam int REQ_W      = 3;
    localparam int WORD_W     = 64;
    localparam int BITN_W     = 32;
    localparam int WIDX_W     = 10;
    localparam int HASH_IDX_W = 16;
    localparam int BIT_SEL_W  = 6;
    localparam int CNT_W      = 3;

    // Stream packing
    localparam int S_TDATA_W  = 176;
    localparam int M_TDATA_W  = 72;
    localparam int HASH_LSB   = 0;
    localparam int BITN_LSB   = 64;
    localparam int WNUM_LSB   = 96;
    localparam int WDATA_LSB  = 106;
    localparam int OUT_PRESENT_POS = 0;
    localparam int OUT_WORD_LSB    = 1;
    localparam int OUT_RANGE_POS   = 65;

    // Hash index lanes
    localparam int LANES   = 4;
    localparam int LANE_W  = 2;
    localparam logic [CNT_W-1:0] MAX_COUNT        = 3'd4;
    localparam logic [CNT_W-1:0] HASH_COUNT_RESET = 3'd4;

    // Word-index reduction: serial remainder, several bits per cycle
    localparam int RED_IN_W      = BITN_W - BIT_SEL_W;
    localparam int RED_VAL_W     = 32;
    localparam int RED_STEP_BITS = 8;
    localparam int RED_STEPS     = RED_VAL_W / RED_STEP_BITS;

    // Command from the sequencer to the word store
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [WIDX_W-1:0] addr;
    } mem_cmd_t;

endpackage

### sv/bfp_lane.sv
module bfp_lane
    import bfp_pkg::*;
#(
    parameter int WORDS = 64
) (
    input  logic                 aclk,
    input  logic                 load,
    input  logic                 step,
    input  logic [RED_IN_W-1:0]  value_in,
    output logic [AW_OUT-1:0]    rem_out
);

    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int AW_OUT = AW;
    localparam logic [AW:0] WORDS_C = (AW+1)'(WORDS);

    logic [RED_VAL_W-1:0] val_reg;
    logic [RED_VAL_W-1:0] val_next;
    logic [AW-1:0]        rem_reg;
    logic [AW-1:0]        rem_next;

    // Fold the next group of bits into the remainder, MSB first
    always_comb begin
        logic [AW-1:0] r;
        logic [AW:0]   t;
        r = rem_reg;
        for (int j = 0; j < RED_STEP_BITS; j++) begin
            t = {r, val_reg[RED_VAL_W-1-j]};
            if (t >= WORDS_C) begin
                t = t - WORDS_C;
            end
            r = t[AW-1:0];
        end
        rem_next = r;
        val_next = val_reg << RED_STEP_BITS;
    end

    // Load a fresh value or advance one step
    always_ff @(posedge aclk) begin
        if (load) begin
            val_reg <= RED_VAL_W'(value_in);
            rem_reg <= '0;
        end else if (step) begin
            val_reg <= val_next;
            rem_reg <= rem_next;
        end
    end

    assign rem_out = rem_reg;

endmodule

### sv/bfp_store.sv
module bfp_store
    import bfp_pkg::*;
#(
    parameter int WORDS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mem_cmd_t          cmd,
    input  logic [WORD_W-1:0] wdata,
    output logic [WORD_W-1:0] rdata,
    output logic              ready
);

    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rdata_reg;
    logic              clr_reg;
    logic [AW-1:0]     clr_addr_reg;

    // Sweep the store to zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_reg) begin
            if (clr_addr_reg == LAST_ADDR) begin
                clr_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (cmd.wr) begin
            mem[cmd.addr[AW-1:0]] <= wdata;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[cmd.addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;
    assign ready = !clr_reg;

endmodule

### sv/bloom_filter_prehashed.sv
// Channel   Direction  Payload
// cfg       in         cfg_data[2:0] = hash_count
// s         in         tuser = req_type; tdata = hash_value, bit_number, word_number, word_data
// m         out        tdata = present, word_out, range_error
//
// One item at a time. Merge and read go straight to the word memory; set bit, test bit and
// hash operations first step the lane remainder units, then pass a read and a write-back
// state per index on the word memory (one index for bit ops, up to four for hashes).
// After reset the store is swept to zero, with s_tready low until the sweep is done.
// A result waiting on m_tready does not block the next accept; only the final hand-off waits.
module bloom_filter_prehashed
    import bfp_pkg::*;
#(
    parameter int WORDS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // cfg_data: hash_count[2:0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: hash_value[63:0], bit_number[95:64], word_number[105:96],
    //          word_data[169:106], zero[175:170]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type[2:0]
    input  logic [REQ_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: present[0], word_out[64:1], range_error[65], zero[71:66]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [WIDX_W:0] WORDS_C = (WIDX_W+1)'(WORDS);
    localparam int SUB_W = HASH_IDX_W - BIT_SEL_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_RD     = 3'd2;
    localparam logic [2:0] ST_WR     = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     hash_count_reg;
    logic [REQ_W-1:0]     req_reg;
    logic [WORD_W-1:0]    wdata_in_reg;
    logic [AW-1:0]        widx_reg;
    logic [BIT_SEL_W-1:0] bit_sel_reg [LANES];
    logic [CNT_W-1:0]     n_reg;
    logic [LANE_W-1:0]    k_reg;
    logic [LANE_W-1:0]    step_reg;
    logic                 hit_reg;
    logic [WORD_W-1:0]    word_out_reg;
    logic                 range_err_reg;
    logic                 m_tvalid_reg;
    logic                 m_present_reg;
    logic [WORD_W-1:0]    m_word_reg;
    logic                 m_range_reg;

    logic                 s_xfer;
    logic                 store_ready;
    logic [REQ_W-1:0]     req_in;
    logic                 is_bit_in;
    logic                 is_word_in;
    logic [WIDX_W-1:0]    wnum_in;
    logic                 wnum_ok;
    logic [CNT_W-1:0]     eff_count;
    logic                 lane_step;
    logic [AW-1:0]        lane_rem [LANES];
    logic [RED_IN_W-1:0]  lane_val [LANES];
    mem_cmd_t             cmd;
    logic [WORD_W-1:0]    mem_wdata;
    logic [WORD_W-1:0]    mem_rdata;
    logic [WORD_W-1:0]    bit_mask;
    logic                 last_idx;
    logic                 out_free;
    logic                 is_test;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && store_ready;
    assign s_xfer    = s_tvalid && s_tready;
    assign req_in    = s_tuser;
    assign is_bit_in  = (req_in == REQ_SET_BIT) || (req_in == REQ_TEST_BIT);
    assign is_word_in = (req_in == REQ_MERGE) || (req_in == REQ_READ);
    assign wnum_in    = s_tdata[WNUM_LSB +: WIDX_W];
    assign wnum_ok    = {1'b0, wnum_in} < WORDS_C;
    assign eff_count  = (hash_count_reg > MAX_COUNT) ? MAX_COUNT : hash_count_reg;
    assign lane_step  = (state_reg == ST_REDUCE);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign last_idx   = (CNT_W'(k_reg) + 1'b1) == n_reg;
    assign is_test    = (req_reg == REQ_TEST) || (req_reg == REQ_TEST_BIT);

    // Hold the configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_count_reg <= HASH_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            hash_count_reg <= cfg_data;
        end
    end

    // Lane inputs: word part of each 16-bit hash index, lane 0 also takes bit_number
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        if (i == 0) begin : g_first
            assign lane_val[i] = is_bit_in ? s_tdata[BITN_LSB+BIT_SEL_W +: RED_IN_W]
                                           : RED_IN_W'(s_tdata[HASH_LSB+BIT_SEL_W +: SUB_W]);
        end else begin : g_rest
            assign lane_val[i] =
                RED_IN_W'(s_tdata[HASH_LSB+HASH_IDX_W*i+BIT_SEL_W +: SUB_W]);
        end

        bfp_lane #(
            .WORDS    (WORDS)
        ) u_lane (
            .aclk     (aclk),
            .load     (s_xfer),
            .step     (lane_step),
            .value_in (lane_val[i]),
            .rem_out  (lane_rem[i])
        );

        // Keep the bit position within the word
        always_ff @(posedge aclk) begin
            if (s_xfer) begin
                if (i == 0 && is_bit_in) begin
                    bit_sel_reg[i] <= s_tdata[BITN_LSB +: BIT_SEL_W];
                end else begin
                    bit_sel_reg[i] <= s_tdata[HASH_LSB+HASH_IDX_W*i +: BIT_SEL_W];
                end
            end
        end
    end

    // Memory command: word ops use word_number, the rest the current lane
    always_comb begin
        cmd.rd   = (state_reg == ST_RD);
        cmd.wr   = 1'b0;
        if ((req_reg == REQ_MERGE) || (req_reg == REQ_READ)) begin
            cmd.addr = WIDX_W'(widx_reg);
        end else begin
            cmd.addr = WIDX_W'(lane_rem[k_reg]);
        end
        bit_mask  = WORD_W'(1) << bit_sel_reg[k_reg];
        mem_wdata = mem_rdata;
        if (state_reg == ST_WR) begin
            unique case (req_reg)
                REQ_ADD, REQ_SET_BIT: begin
                    cmd.wr    = 1'b1;
                    mem_wdata = mem_rdata | bit_mask;
                end
                REQ_REMOVE: begin
                    cmd.wr    = 1'b1;
                    mem_wdata = mem_rdata & ~bit_mask;
                end
                REQ_MERGE: begin
                    cmd.wr    = 1'b1;
                    mem_wdata = mem_rdata | wdata_in_reg;
                end
                default: begin
                    cmd.wr = 1'b0;
                end
            endcase
        end
    end

    bfp_store #(
        .WORDS   (WORDS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .wdata   (mem_wdata),
        .rdata   (mem_rdata),
        .ready   (store_ready)
    );

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (is_word_in) begin
                        state_next = wnum_ok ? ST_RD : ST_FINISH;
                    end else if (req_in <= REQ_TEST_BIT) begin
                        state_next = ST_REDUCE;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_REDUCE: begin
                if (step_reg == LANE_W'(RED_STEPS - 1)) begin
                    state_next = (n_reg == '0) ? ST_FINISH : ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_WR;
            end
            ST_WR: begin
                state_next = last_idx ? ST_FINISH : ST_RD;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item registers and merge of lane results
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_reg       <= req_in;
            wdata_in_reg  <= s_tdata[WDATA_LSB +: WORD_W];
            widx_reg      <= wnum_in[AW-1:0];
            n_reg         <= (is_bit_in || is_word_in) ? CNT_W'(1) : eff_count;
            k_reg         <= '0;
            step_reg      <= '0;
            hit_reg       <= 1'b1;
            word_out_reg  <= '0;
            range_err_reg <= is_word_in && !wnum_ok;
        end else begin
            if (state_reg == ST_REDUCE) begin
                step_reg <= step_reg + 1'b1;
            end
            if (state_reg == ST_WR) begin
                k_reg <= k_reg + 1'b1;
                if (is_test) begin
                    hit_reg <= hit_reg & mem_rdata[bit_sel_reg[k_reg]];
                end
                if (req_reg == REQ_READ) begin
                    word_out_reg <= mem_rdata;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_present_reg <= hit_reg & is_test;
            m_word_reg    <= word_out_reg;
            m_range_reg   <= range_err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_range_reg, m_word_reg, m_present_reg});

endmodule

### sv/bfp_checker.sv
module bfp_checker
    import bfp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result stays and holds its payload
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // One item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // A range error never reports a test hit
    a_err_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[OUT_PRESENT_POS] && m_tdata[OUT_RANGE_POS]))
        else $error("present and range_error both set");

    // A returned word comes only from a read, never with a hit or an error
    a_word_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[OUT_WORD_LSB +: WORD_W] != '0)
            |-> !m_tdata[OUT_PRESENT_POS] && !m_tdata[OUT_RANGE_POS])
        else $error("word_out set together with another flag");

endmodule

bind bloom_filter_prehashed bfp_checker u_bfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bfp_pkg::*;

    localparam int          WORDS        = 64;
    localparam int unsigned NBITS        = WORDS * 64;
    localparam int          DRAIN_CYCLES = 32;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [WORD_W-1:0] hash;
        logic [BITN_W-1:0] bitn;
        logic [WIDX_W-1:0] wnum;
        logic [WORD_W-1:0] wdata;
    } bf_req_t;

    typedef struct packed {
        logic              present;
        logic [WORD_W-1:0] word;
        logic              range_err;
    } bf_resp_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [REQ_W-1:0]     s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the filter store and its hash count
    logic [WORD_W-1:0] filt_words [WORDS] = '{default: '0};
    logic [CNT_W-1:0]  filt_count = HASH_COUNT_RESET;

    bf_resp_t          pending_resp [$];
    logic [WORD_W-1:0] hash_pool [$];
    logic [BITN_W-1:0] last_set_bit = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold_goal   = 0;
    int rx_hold_count  = 0;
    int errs           = 0;

    bloom_filter_prehashed #(.WORDS(WORDS)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Apply one request to the shadow store and return its response
    function automatic bf_resp_t bf_apply(input bf_req_t r);
        bf_resp_t    res;
        int unsigned n;
        int unsigned b;
        res = '0;
        n = (filt_count > MAX_COUNT) ? MAX_COUNT : filt_count;
        case (r.kind)
            REQ_ADD, REQ_REMOVE, REQ_TEST: begin
                res.present = (r.kind == REQ_TEST);
                for (int i = 0; i < n; i++) begin
                    b = r.hash[16*i +: 16] % NBITS;
                    if (r.kind == REQ_ADD)
                        filt_words[b / 64][b % 64] = 1'b1;
                    else if (r.kind == REQ_REMOVE)
                        filt_words[b / 64][b % 64] = 1'b0;
                    else if (!filt_words[b / 64][b % 64])
                        res.present = 1'b0;
                end
            end
            REQ_SET_BIT: begin
                b = r.bitn % NBITS;
                filt_words[b / 64][b % 64] = 1'b1;
            end
            REQ_TEST_BIT: begin
                b = r.bitn % NBITS;
                res.present = filt_words[b / 64][b % 64];
            end
            REQ_MERGE: begin
                if (r.wnum < WORDS)
                    filt_words[r.wnum] = filt_words[r.wnum] | r.wdata;
                else
                    res.range_err = 1'b1;
            end
            REQ_READ: begin
                if (r.wnum < WORDS)
                    res.word = filt_words[r.wnum];
                else
                    res.range_err = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic bf_req_t make_req(input logic [REQ_W-1:0] kind,
                                         input logic [WORD_W-1:0] hash,
                                         input logic [BITN_W-1:0] bitn,
                                         input logic [WIDX_W-1:0] wnum,
                                         input logic [WORD_W-1:0] wdata);
        bf_req_t r;
        r.kind  = kind;
        r.hash  = hash;
        r.bitn  = bitn;
        r.wnum  = wnum;
        r.wdata = wdata;
        return r;
    endfunction

    // Build one random request; remove and test mostly reuse hashes added earlier
    function automatic bf_req_t random_request();
        bf_req_t     r;
        int unsigned pick;
        r.hash  = {$urandom, $urandom};
        r.bitn  = $urandom;
        r.wnum  = $urandom_range(1023);
        r.wdata = {$urandom, $urandom};
        pick    = $urandom_range(99);
        if (pick < 20) begin
            r.kind = REQ_ADD;
            if (hash_pool.size() > 0 && $urandom_range(3) == 0)
                r.hash = hash_pool[$urandom_range(hash_pool.size() - 1)];
            else begin
                hash_pool.push_back(r.hash);
                if (hash_pool.size() > 32)
                    void'(hash_pool.pop_front());
            end
        end else if (pick < 55) begin
            r.kind = (pick < 30) ? REQ_REMOVE : REQ_TEST;
            if (hash_pool.size() > 0 && $urandom_range(9) < 7)
                r.hash = hash_pool[$urandom_range(hash_pool.size() - 1)];
        end else if (pick < 65) begin
            r.kind = REQ_SET_BIT;
            last_set_bit = r.bitn;
        end else if (pick < 77) begin
            r.kind = REQ_TEST_BIT;
            // alias the last set bit through the upper bits
            if ($urandom_range(1) == 0)
                r.bitn = {r.bitn[BITN_W-1:12], last_set_bit[11:0]};
        end else if (pick < 85) begin
            r.kind = REQ_MERGE;
            if ($urandom_range(4) != 0)
                r.wnum = $urandom_range(WORDS - 1);
            if ($urandom_range(1) == 0)
                r.wdata = r.wdata & {$urandom, $urandom} & {$urandom, $urandom};
        end else if (pick < 97) begin
            r.kind = REQ_READ;
            if ($urandom_range(6) != 0)
                r.wnum = $urandom_range(WORDS - 1);
        end else begin
            r.kind = REQ_UNUSED;
        end
        return r;
    endfunction

    // Offer one request, wait for the transfer, then queue its prediction
    task automatic send_item(input bf_req_t r);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[HASH_LSB  +: WORD_W] = r.hash;
        d[BITN_LSB  +: BITN_W] = r.bitn;
        d[WNUM_LSB  +: WIDX_W] = r.wnum;
        d[WDATA_LSB +: WORD_W] = r.wdata;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        pending_resp.push_back(bf_apply(r));
    endtask

    // Stop offering and wait until every response has arrived
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_resp.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_hash_count(input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        filt_count = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Field extremes, every request code, and the range and unused-code cases
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(make_req(REQ_TEST, '0, '0, '0, '0));
        send_item(make_req(REQ_ADD, '1, '0, '0, '0));
        send_item(make_req(REQ_TEST, '1, '0, '0, '0));
        send_item(make_req(REQ_TEST_BIT, '0, '1, '0, '0));
        send_item(make_req(REQ_READ, '0, '0, WIDX_W'(WORDS - 1), '0));
        send_item(make_req(REQ_REMOVE, '1, '0, '0, '0));
        send_item(make_req(REQ_TEST_BIT, '0, BITN_W'(NBITS), '0, '0));
        send_item(make_req(REQ_SET_BIT, '0, '0, '0, '0));
        send_item(make_req(REQ_TEST, '0, '0, '0, '0));
        send_item(make_req(REQ_MERGE, '0, '0, '0, '1));
        send_item(make_req(REQ_MERGE, '0, '0, WIDX_W'(WORDS), '1));
        send_item(make_req(REQ_READ, '0, '0, '1, '0));
        send_item(make_req(REQ_READ, '0, '0, '0, '0));
        send_item(make_req(REQ_UNUSED, '1, '1, '1, '1));
    endtask

    // Zero, one, above-max and reset hash counts, including zero-count test
    task automatic test_hash_count();
        logic [CNT_W-1:0]  counts [4] = '{3'd0, 3'd1, 3'd7, 3'd4};
        logic [WORD_W-1:0] h;
        foreach (counts[k]) begin
            wait_drain();
            write_hash_count(counts[k]);
            h = {$urandom, $urandom};
            send_item(make_req(REQ_ADD, h, '0, '0, '0));
            send_item(make_req(REQ_TEST, h, '0, '0, '0));
            send_item(make_req(REQ_TEST, {$urandom, $urandom}, '0, '0, '0));
        end
    endtask

    // Random traffic under each idle pattern, new hash count per phase
    task automatic test_random_traffic();
        int               send_pcts [4] = '{0, 76, 0, 25};
        int               recv_pcts [4] = '{0, 0, 76, 25};
        logic [CNT_W-1:0] counts [4]    = '{3'd3, 3'd5, 3'd6, 3'd2};
        foreach (send_pcts[p]) begin
            wait_drain();
            write_hash_count(counts[p]);
            for (int k = 0; k < 360; k++) begin
                // keep short stretches with no idling in every phase
                send_idle_pct  = (k % 50 < 10) ? 0 : send_pcts[p];
                recv_stall_pct = (k % 50 < 10) ? 0 : recv_pcts[p];
                send_item(random_request());
            end
        end
    endtask

    // Long receiver hold-off with the sender still offering, then a full pause and stalled traffic
    task automatic test_backpressure();
        wait_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rx_hold_goal   = rx_hold_count + HOLD_CYCLES;
        for (int k = 0; k < 40; k++)
            send_item(random_request());
        wait_drain();
        recv_stall_pct = 50;
        for (int k = 0; k < 20; k++)
            send_item(random_request());
    endtask

    // Drive the receiver ready, honoring a requested hold-off
    always @(posedge aclk) begin
        if (rx_hold_count < rx_hold_goal) begin
            m_tready      <= 1'b0;
            rx_hold_count <= rx_hold_count + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : check_results
        bf_resp_t got;
        bf_resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.present   = m_tdata[OUT_PRESENT_POS];
            got.word      = m_tdata[OUT_WORD_LSB +: WORD_W];
            got.range_err = m_tdata[OUT_RANGE_POS];
            if (pending_resp.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                errs++;
            end else begin
                want = pending_resp.pop_front();
                if (got.present !== want.present) begin
                    $display("%0t: present mismatch, expected %b, actual %b",
                             $time, want.present, got.present);
                    errs++;
                end
                if (got.word !== want.word) begin
                    $display("%0t: word_out mismatch, expected %h, actual %h",
                             $time, want.word, got.word);
                    errs++;
                end
                if (got.range_err !== want.range_err) begin
                    $display("%0t: range_error mismatch, expected %b, actual %b",
                             $time, want.range_err, got.range_err);
                    errs++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_hash_count();
        test_random_traffic();
        test_backpressure();
        wait_drain();
        if (errs == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop in case the block hangs
    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/bfp_pkg.sv
sv/bfp_lane.sv
sv/bfp_store.sv
sv/bloom_filter_prehashed.sv
sv/bfp_checker.sv
verif/tb_top.sv
